@@ sv/plcm_pkg.sv @@
// Package for the piecewise-linear color map: widths, codes, pipeline sideband.
// Used by plcm_div, plcm_lane and piecewise_linear_color_map.
package plcm_pkg;

	localparam int DATA_W          = 16;
	localparam int CNT_W           = 5;
	localparam int CFG_IDX_W       = 2;
	localparam int DIV_STAGES      = DATA_W;
	localparam int MAX_POINTS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_POINTS   = 2'd0,
		CFG_GREEN_POINTS = 2'd1,
		CFG_BLUE_POINTS  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_WRITE  = 1'b1
	} req_t;

	// Sideband that travels with an item through the interpolation pipe
	typedef struct packed {
		logic              valid;
		logic              zero_all;
		logic              direct;
		logic              neg;
		logic [DATA_W-1:0] v0;
		logic [DATA_W-1:0] dval;
	} side_t;

endpackage

@@ sv/plcm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on plcm_pkg.
module plcm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [2*plcm_pkg::DATA_W-1:0]       dividend,
	input  logic [plcm_pkg::DATA_W-1:0]         divisor,
	input  plcm_pkg::side_t                     side_in,
	output logic [plcm_pkg::DATA_W-1:0]         quotient,
	output plcm_pkg::side_t                     side_out
);

	localparam int W = plcm_pkg::DATA_W;
	localparam int N = plcm_pkg::DIV_STAGES;

	logic [W-1:0]    rem_s  [N+1];
	logic [W-1:0]    low_s  [N+1];
	logic [W-1:0]    quo_s  [N+1];
	logic [W-1:0]    div_s  [N+1];
	plcm_pkg::side_t side_s [N+1];

	// Stage 0 is the unregistered entry point
	assign rem_s[0]  = dividend[2*W-1:W];
	assign low_s[0]  = dividend[W-1:0];
	assign quo_s[0]  = '0;
	assign div_s[0]  = divisor;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		logic       take;

		// Shift in the next dividend bit and try a subtract
		always_comb begin
			trial = {rem_s[i], low_s[i][W-1]};
			diff  = trial - {1'b0, div_s[i]};
			take  = (trial >= {1'b0, div_s[i]});
		end

		// Sideband moves with the stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i+1] <= '0;
			end else begin
				side_s[i+1] <= side_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? diff[W-1:0] : trial[W-1:0];
			low_s[i+1] <= {low_s[i][W-2:0], 1'b0};
			quo_s[i+1] <= {quo_s[i][W-2:0], take};
			div_s[i+1] <= div_s[i];
		end
	end

	assign quotient = quo_s[N];
	assign side_out = side_s[N];

endmodule

@@ sv/plcm_lane.sv @@
// One color channel: breakpoint table, search, operand select, multiply,
// divide and saturate. Depends on plcm_pkg and plcm_div.
module plcm_lane #(
	parameter int MAX_POINTS = plcm_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [3:0]                    wr_entry,
	input  logic [plcm_pkg::DATA_W-1:0]   wr_pos,
	input  logic [plcm_pkg::DATA_W-1:0]   wr_col,
	input  logic                          in_valid,
	input  logic                          zero_all,
	input  logic [plcm_pkg::DATA_W-1:0]   smp,
	input  logic [plcm_pkg::CNT_W-1:0]    cnt,
	output logic                          out_valid,
	output logic [plcm_pkg::DATA_W-1:0]   out_value
);

	localparam int W = plcm_pkg::DATA_W;

	logic [W-1:0] pos_q [MAX_POINTS];
	logic [W-1:0] col_q [MAX_POINTS];

	// Table write, slot decoded per entry
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (wr_en && (32'(wr_entry) == k)) begin
				pos_q[k] <= wr_pos;
				col_q[k] <= wr_col;
			end
		end
	end

	// Search: first used slot at or above the sample
	logic [8:0]            used;
	logic [MAX_POINTS-1:0] hit, first, last, sel1, sel0;
	logic                  none;
	logic [W-1:0]          p0, p1, v0, v1;

	always_comb begin
		used = (9'(cnt) > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : 9'(cnt);
		for (int k = 0; k < MAX_POINTS; k++) begin
			hit[k]  = (9'(k) < used) && (smp <= pos_q[k]);
			last[k] = (9'(k) == (used - 9'd1));
		end
		first = hit & (~hit + MAX_POINTS'(1));
		none  = ~|hit;
		sel1  = none ? last : first;
		sel0  = sel1 >> 1;
		p0 = '0;
		p1 = '0;
		v0 = '0;
		v1 = '0;
		for (int k = 0; k < MAX_POINTS; k++) begin
			p0 = p0 | (pos_q[k] & {W{sel0[k]}});
			v0 = v0 | (col_q[k] & {W{sel0[k]}});
			p1 = p1 | (pos_q[k] & {W{sel1[k]}});
			v1 = v1 | (col_q[k] & {W{sel1[k]}});
		end
	end

	logic         valid_s2, zero_s2, direct_s2;
	logic [W-1:0] p0_s2, p1_s2, v0_s2, v1_s2, smp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2   <= zero_all;
		direct_s2 <= none | first[0];
		p0_s2     <= p0;
		p1_s2     <= p1;
		v0_s2     <= v0;
		v1_s2     <= v1;
		smp_s2    <= smp;
	end

	// Differences and sign of the color step
	logic [W:0] dp, dv;
	logic [W-1:0] ds;

	always_comb begin
		dp = {1'b0, p1_s2} - {1'b0, p0_s2};
		dv = {1'b0, v1_s2} - {1'b0, v0_s2};
		ds = smp_s2 - p0_s2;
	end

	logic         valid_s3, zero_s3, direct_s3, neg_s3;
	logic [W-1:0] ds_s3, mag_s3, dp_s3, v0_s3, dval_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		zero_s3   <= zero_s2;
		direct_s3 <= direct_s2 | dp[W] | (dp == '0);
		dval_s3   <= direct_s2 ? v1_s2 : v0_s2;
		neg_s3    <= dv[W];
		mag_s3    <= dv[W] ? W'(-dv) : dv[W-1:0];
		ds_s3     <= ds;
		dp_s3     <= dp[W-1:0];
		v0_s3     <= v0_s2;
	end

	// Product of position offset and color step magnitude
	logic [2*W-1:0]  prod_s4;
	logic [W-1:0]    dp_s4;
	plcm_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4.valid    <= valid_s3;
			side_s4.zero_all <= zero_s3;
			side_s4.direct   <= direct_s3;
			side_s4.neg      <= neg_s3;
			side_s4.v0       <= v0_s3;
			side_s4.dval     <= dval_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= ds_s3 * mag_s3;
		dp_s4   <= dp_s3;
	end

	logic [W-1:0]    quo;
	plcm_pkg::side_t side_d;

	plcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.dividend (prod_s4),
		.divisor  (dp_s4),
		.side_in  (side_s4),
		.quotient (quo),
		.side_out (side_d)
	);

	// Apply the step to the color of the lower breakpoint and saturate
	logic [W:0]   sum;
	logic [W-1:0] res;

	always_comb begin
		if (side_d.neg) begin
			sum = {1'b0, side_d.v0} - {1'b0, quo};
			res = sum[W] ? '0 : sum[W-1:0];
		end else begin
			sum = {1'b0, side_d.v0} + {1'b0, quo};
			res = sum[W] ? '1 : sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= side_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_value <= side_d.zero_all ? '0 : (side_d.direct ? side_d.dval : res);
	end

endmodule

@@ sv/piecewise_linear_color_map.sv @@
// Piecewise-linear color map, top level.
// Pipeline: a lookup's result strobe comes after the input stage, three lane stages, 16 divider
// stages and the output register.
// Throughput: one item per cycle; busy stays low, the 16-stage divider is fully pipelined.
// Reset clears the point counts and all valid bits; tables are undefined until written.
// The receiver cannot stall: result_valid is a one-cycle strobe; writes give no result.
module piecewise_linear_color_map #(
	parameter int MAX_POINTS  = plcm_pkg::MAX_POINTS_DEF,
	parameter int SAMPLE_BITS = plcm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic [1:0]                       channel,
	input  logic [3:0]                       entry,
	input  logic [15:0]                      point_position,
	input  logic [15:0]                      point_color,
	input  logic [15:0]                      sample,
	output logic                             result_valid,
	output logic [15:0]                      red,
	output logic [15:0]                      green,
	output logic [15:0]                      blue,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [plcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plcm_pkg::CNT_W-1:0]       cfg_data
);

	localparam int W = plcm_pkg::DATA_W;
	localparam logic [W-1:0] SMASK = (SAMPLE_BITS >= W) ? '1 :
		W'((64'd1 << SAMPLE_BITS) - 64'd1);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Point count registers
	logic [plcm_pkg::CNT_W-1:0] red_cnt_q, green_cnt_q, blue_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q   <= '0;
			green_cnt_q <= '0;
			blue_cnt_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (plcm_pkg::cfg_idx_t'(cfg_index))
				plcm_pkg::CFG_RED_POINTS:   red_cnt_q   <= cfg_data;
				plcm_pkg::CFG_GREEN_POINTS: green_cnt_q <= cfg_data;
				plcm_pkg::CFG_BLUE_POINTS:  blue_cnt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept decode
	logic acc, is_wr, wr_r, wr_g, wr_b;

	always_comb begin
		acc   = start && !busy;
		is_wr = acc && (plcm_pkg::req_t'(req_type) == plcm_pkg::REQ_WRITE);
		wr_r  = is_wr && (plcm_pkg::chan_t'(channel) == plcm_pkg::CH_RED);
		wr_g  = is_wr && (plcm_pkg::chan_t'(channel) == plcm_pkg::CH_GREEN);
		wr_b  = is_wr && (plcm_pkg::chan_t'(channel) == plcm_pkg::CH_BLUE);
	end

	// Input stage for lookups
	logic         valid_s1, zero_s1;
	logic [W-1:0] smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc && (plcm_pkg::req_t'(req_type) == plcm_pkg::REQ_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		smp_s1  <= sample & SMASK;
		zero_s1 <= (red_cnt_q == '0) || (green_cnt_q == '0) || (blue_cnt_q == '0);
	end

	logic vr, vg, vb;

	plcm_lane #(.MAX_POINTS(MAX_POINTS)) u_red (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_r), .wr_entry(entry),
		.wr_pos(point_position), .wr_col(point_color), .in_valid(valid_s1),
		.zero_all(zero_s1), .smp(smp_s1), .cnt(red_cnt_q),
		.out_valid(vr), .out_value(red)
	);

	plcm_lane #(.MAX_POINTS(MAX_POINTS)) u_green (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_g), .wr_entry(entry),
		.wr_pos(point_position), .wr_col(point_color), .in_valid(valid_s1),
		.zero_all(zero_s1), .smp(smp_s1), .cnt(green_cnt_q),
		.out_valid(vg), .out_value(green)
	);

	plcm_lane #(.MAX_POINTS(MAX_POINTS)) u_blue (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_b), .wr_entry(entry),
		.wr_pos(point_position), .wr_col(point_color), .in_valid(valid_s1),
		.zero_all(zero_s1), .smp(smp_s1), .cnt(blue_cnt_q),
		.out_valid(vb), .out_value(blue)
	);

	assign result_valid = vr;

	// Lanes run in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vr == vg) && (vr == vb))
		else $error("lane valids diverged");

	// A result only follows an accepted lookup
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && !req_type, 21))
		else $error("result without matching lookup");

	// An empty red table forces black
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(red_cnt_q == '0, 21) |->
			(red == '0) && (green == '0) && (blue == '0))
		else $error("zero count did not force zero output");

endmodule
